### design/sts_pkg.sv
// Shared types and constants for the source token scanner.
`default_nettype none
package sts_pkg;

  typedef enum logic [3:0] {
    KIND_IDENT  = 4'd0,
    KIND_FUNC   = 4'd1,
    KIND_RETURN = 4'd2,
    KIND_I32    = 4'd3,
    KIND_INT    = 4'd4,
    KIND_ARROW  = 4'd5,
    KIND_LPAREN = 4'd6,
    KIND_RPAREN = 4'd7,
    KIND_LBRACE = 4'd8,
    KIND_RBRACE = 4'd9,
    KIND_SEMI   = 4'd10,
    KIND_ERROR  = 4'd11
  } kind_e;

  // Scanner modes, one-hot
  typedef enum logic [7:0] {
    MODE_IDLE  = 8'b0000_0001,
    MODE_IDENT = 8'b0000_0010,
    MODE_ZERO  = 8'b0000_0100,
    MODE_OCT   = 8'b0000_1000,
    MODE_HEX   = 8'b0001_0000,
    MODE_BIN   = 8'b0010_0000,
    MODE_DEC   = 8'b0100_0000,
    MODE_MINUS = 8'b1000_0000
  } mode_e;

  localparam logic [7:0] SepReset = 8'd39;
  localparam logic [7:0] ChNewline = 8'h0a;

  // Keyword letter at a position (0 where the keyword has ended)
  function automatic logic [7:0] kw_char(input logic [1:0] kw, input logic [2:0] pos);
    logic [7:0] r;
    r = 8'd0;
    case (kw)
      2'd0: case (pos)
        3'd0: r = "f"; 3'd1: r = "u"; 3'd2: r = "n"; 3'd3: r = "c";
        default: r = 8'd0;
      endcase
      2'd1: case (pos)
        3'd0: r = "r"; 3'd1: r = "e"; 3'd2: r = "t"; 3'd3: r = "u";
        3'd4: r = "r"; 3'd5: r = "n";
        default: r = 8'd0;
      endcase
      2'd2: case (pos)
        3'd0: r = "i"; 3'd1: r = "3"; 3'd2: r = "2";
        default: r = 8'd0;
      endcase
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### design/source_token_scanner_core.sv
// Top level of the source token scanner.
// One character word is taken per clock whenever full is low; its tokens
// (none, one or two) are computed in the same cycle by the scanner front end
// and written into a four-word token queue, from which one token word leaves
// per pop. full rises when fewer than two queue entries are free, so the
// rate is one character per cycle while tokens are drained as fast as they
// are made. Tokens are registered in the queue before reaching the outputs.
`default_nettype none
module source_token_scanner_core import sts_pkg::*; #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COL_BITS    = 16,
  parameter int LENGTH_BITS = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [7:0]             cfg_wdata_i,
  input  wire logic                   push,
  output logic                        full,
  input  wire logic [7:0]             char_code_i,
  input  wire logic                   end_of_text_i,
  output logic                        empty,
  input  wire logic                   pop,
  output logic [3:0]                  token_kind_o,
  output logic [OFFSET_BITS-1:0]      start_offset_o,
  output logic [LINE_BITS-1:0]        start_line_o,
  output logic [COL_BITS-1:0]         start_col_o,
  output logic [OFFSET_BITS-1:0]      end_offset_o,
  output logic [LINE_BITS-1:0]        end_line_o,
  output logic [COL_BITS-1:0]         end_col_o,
  output logic [LENGTH_BITS-1:0]      text_length_o,
  output logic                        last_of_run_o
);

  localparam int WordBits = 4 + 2 * (OFFSET_BITS + LINE_BITS + COL_BITS) + LENGTH_BITS;

  logic [7:0] sep_q;
  logic accept, res_valid, room;
  logic [1:0] res_cnt;
  logic [WordBits-1:0] res0, res1, head;

  // Separator register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) sep_q <= SepReset;
    else if (cfg_we_i) sep_q <= cfg_wdata_i;
  end

  assign full   = !room;
  assign accept = push && room;

  sts_front #(
    .OffsetBits(OFFSET_BITS), .LineBits(LINE_BITS), .ColBits(COL_BITS),
    .LengthBits(LENGTH_BITS), .WordBits(WordBits)
  ) u_front (
    .clk_i, .rst_ni, .sep_i(sep_q), .valid_i(accept), .char_i(char_code_i),
    .eot_i(end_of_text_i), .res_valid_o(res_valid), .res_cnt_o(res_cnt),
    .res0_o(res0), .res1_o(res1)
  );

  sts_back #(.WordBits(WordBits)) u_back (
    .clk_i, .rst_ni, .wr_i(res_valid), .wr_cnt_i(res_cnt), .wr0_i(res0), .wr1_i(res1),
    .room_o(room), .empty_o(empty), .pop_i(pop), .head_o(head),
    .head_last_o(last_of_run_o)
  );

  assign {token_kind_o, start_offset_o, start_line_o, start_col_o,
          end_offset_o, end_line_o, end_col_o, text_length_o} = head;

endmodule
`default_nettype wire

### design/sts_front.sv
// Front part: location tracking, character classes and the token state machine.
`default_nettype none
module sts_front import sts_pkg::*; #(
  parameter int OffsetBits = 24,
  parameter int LineBits   = 20,
  parameter int ColBits    = 16,
  parameter int LengthBits = 8,
  parameter int WordBits   = 4 + 2 * (OffsetBits + LineBits + ColBits) + LengthBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          sep_i,
  input  wire logic                valid_i,
  input  wire logic [7:0]          char_i,
  input  wire logic                eot_i,
  output logic                     res_valid_o,
  output logic [1:0]               res_cnt_o,
  output logic [WordBits-1:0]      res0_o,
  output logic [WordBits-1:0]      res1_o
);

  mode_e mode_q, mode_d;
  logic [2:0] hits_q, hits_d;
  logic sep_q, sep_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [OffsetBits-1:0] so_q, so_d, lo_q, lo_d, no_q, no_d;
  logic [LineBits-1:0] sl_q, sl_d, ll_q, ll_d, nl_q, nl_d;
  logic [ColBits-1:0] sc_q, sc_d, lc_q, lc_d, nc_q, nc_d;

  logic [1:0] cnt;
  logic [WordBits-1:0] w0, w1;
  logic c_alpha, c_digit, c_xdig, c_istart, c_ident, c_space, c_oct;
  logic consumed;
  kind_e fk;
  logic [LengthBits-1:0] len_inc;

  // Character classes
  always_comb begin
    c_alpha  = (char_i >= "A" && char_i <= "Z") || (char_i >= "a" && char_i <= "z");
    c_digit  = char_i >= "0" && char_i <= "9";
    c_oct    = char_i >= "0" && char_i <= "7";
    c_xdig   = c_digit || (char_i >= "a" && char_i <= "f") || (char_i >= "A" && char_i <= "F");
    c_istart = c_alpha || char_i == "_";
    c_ident  = c_istart || c_digit;
    c_space  = char_i == 8'd32 || (char_i >= 8'd9 && char_i <= 8'd13);
    len_inc  = (&len_q) ? len_q : len_q + 1'b1;
  end

  function automatic logic [LengthBits-1:0] len_of(input int unsigned v);
    return LengthBits'(v);
  endfunction

  // Token state machine for one character
  always_comb begin
    kind_e k;
    logic [LengthBits-1:0] el;
    logic [WordBits-1:0] w;
    logic [3:0] kwl;
    mode_d = mode_q; hits_d = hits_q; sep_d = sep_q; len_d = len_q;
    so_d = so_q; sl_d = sl_q; sc_d = sc_q;
    lo_d = lo_q; ll_d = ll_q; lc_d = lc_q;
    no_d = no_q; nl_d = nl_q; nc_d = nc_q;
    cnt = 2'd0; w0 = '0; w1 = '0; consumed = 1'b0; fk = KIND_IDENT; k = KIND_IDENT;
    el = '0; w = '0; kwl = 4'd0;
    if (valid_i) begin
      // extend
      unique case (mode_q)
        MODE_IDENT: if (c_ident) begin
          for (int i = 0; i < 3; i++) begin
            kwl = (i == 0) ? 4'd4 : (i == 1) ? 4'd6 : 4'd3;
            if (len_q >= LengthBits'(kwl) ||
                kw_char(2'(i), len_q[2:0]) != char_i)
              hits_d[i] = 1'b0;
          end
          len_d = len_inc; sep_d = 1'b0; consumed = 1'b1;
        end
        MODE_ZERO: begin
          if (char_i == "x") begin mode_d = MODE_HEX; sep_d = 1'b1; consumed = 1'b1; end
          else if (char_i == "b") begin mode_d = MODE_BIN; sep_d = 1'b1; consumed = 1'b1; end
          else if (c_oct) begin mode_d = MODE_OCT; sep_d = 1'b0; consumed = 1'b1; end
          if (consumed) len_d = len_inc;
        end
        MODE_OCT, MODE_HEX, MODE_BIN, MODE_DEC: begin
          if (!sep_q && char_i == sep_i) begin
            sep_d = 1'b1; consumed = 1'b1;
          end else if ((mode_q == MODE_OCT && c_oct) || (mode_q == MODE_HEX && c_xdig) ||
                       (mode_q == MODE_BIN && (char_i == "0" || char_i == "1")) ||
                       (mode_q == MODE_DEC && c_digit)) begin
            sep_d = 1'b0; len_d = len_inc; consumed = 1'b1;
          end
        end
        MODE_MINUS: if (char_i == ">") begin
          consumed = 1'b1;
          w = {KIND_ARROW, so_q, sl_q, sc_q, no_q, nl_q, nc_q, len_of(2)};
          w0 = w; cnt = 2'd1;
          mode_d = MODE_IDLE;
        end
        default: consumed = 1'b0;
      endcase
      if (consumed) begin
        lo_d = no_q; ll_d = nl_q; lc_d = nc_q;
      end else begin
        // flush pending token
        if (mode_q != MODE_IDLE) begin
          if (mode_q == MODE_IDENT) begin
            k = KIND_IDENT;
            if (hits_q[0] && len_q == len_of(4)) k = KIND_FUNC;
            if (hits_q[1] && len_q == len_of(6)) k = KIND_RETURN;
            if (hits_q[2] && len_q == len_of(3)) k = KIND_I32;
            el = len_q;
          end else if (mode_q == MODE_MINUS) begin
            k = KIND_ERROR; el = len_of(1);
          end else begin
            k = KIND_INT; el = len_q;
          end
          w0 = {k, so_q, sl_q, sc_q, lo_q, ll_q, lc_q, el}; cnt = 2'd1;
        end
        mode_d = MODE_IDLE; sep_d = 1'b0; hits_d = 3'b000;
        // scan afresh
        if (!c_space) begin
          so_d = no_q; sl_d = nl_q; sc_d = nc_q;
          lo_d = no_q; ll_d = nl_q; lc_d = nc_q;
          len_d = len_of(1);
          if (c_istart) begin
            mode_d = MODE_IDENT;
            hits_d = {char_i == "i", char_i == "r", char_i == "f"};
          end else if (char_i == "0") begin
            mode_d = MODE_ZERO; sep_d = 1'b1;
          end else if (c_digit) mode_d = MODE_DEC;
          else if (char_i == "-") mode_d = MODE_MINUS;
          else begin
            case (char_i)
              "(": fk = KIND_LPAREN;
              ")": fk = KIND_RPAREN;
              "{": fk = KIND_LBRACE;
              "}": fk = KIND_RBRACE;
              ";": fk = KIND_SEMI;
              default: fk = KIND_ERROR;
            endcase
            w = {fk, no_q, nl_q, nc_q, no_q, nl_q, nc_q, len_of(1)};
            if (cnt == 2'd0) w0 = w; else w1 = w;
            cnt = cnt + 2'd1;
          end
        end
      end
      // end of text flushes whatever is pending
      if (eot_i) begin
        if (mode_d != MODE_IDLE) begin
          if (mode_d == MODE_IDENT) begin
            k = KIND_IDENT;
            if (hits_d[0] && len_d == len_of(4)) k = KIND_FUNC;
            if (hits_d[1] && len_d == len_of(6)) k = KIND_RETURN;
            if (hits_d[2] && len_d == len_of(3)) k = KIND_I32;
            el = len_d;
          end else if (mode_d == MODE_MINUS) begin
            k = KIND_ERROR; el = len_of(1);
          end else begin
            k = KIND_INT; el = len_d;
          end
          w = {k, so_d, sl_d, sc_d, lo_d, ll_d, lc_d, el};
          if (cnt == 2'd0) w0 = w; else if (cnt == 2'd1) w1 = w;
          if (cnt != 2'd2) cnt = cnt + 2'd1;
        end
        mode_d = MODE_IDLE; sep_d = 1'b0; hits_d = 3'b000;
      end
      // location of the next character
      nc_d = (&nc_q) ? nc_q : nc_q + 1'b1;
      if (char_i == ChNewline) begin
        nc_d = '0;
        nl_d = (&nl_q) ? nl_q : nl_q + 1'b1;
      end
      no_d = (&no_q) ? no_q : no_q + 1'b1;
      if (eot_i) begin
        no_d = '0; nl_d = LineBits'(1); nc_d = ColBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE; hits_q <= '0; sep_q <= 1'b0; len_q <= '0;
      so_q <= '0; sl_q <= LineBits'(1); sc_q <= ColBits'(1);
      lo_q <= '0; ll_q <= LineBits'(1); lc_q <= ColBits'(1);
      no_q <= '0; nl_q <= LineBits'(1); nc_q <= ColBits'(1);
    end else begin
      mode_q <= mode_d; hits_q <= hits_d; sep_q <= sep_d; len_q <= len_d;
      so_q <= so_d; sl_q <= sl_d; sc_q <= sc_d;
      lo_q <= lo_d; ll_q <= ll_d; lc_q <= lc_d;
      no_q <= no_d; nl_q <= nl_d; nc_q <= nc_d;
    end
  end

  assign res_valid_o = valid_i && cnt != 2'd0;
  assign res_cnt_o   = cnt;
  assign res0_o      = w0;
  assign res1_o      = w1;

  // A result word is only produced for an accepted character
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> valid_i)
    else $error("result without character");
  // End of text leaves the scanner idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_i && eot_i |=> mode_q == MODE_IDLE)
    else $error("mode not idle after end of text");
  // End of text resets the next location
  assert property (@(posedge clk_i) disable iff (!rst_ni) valid_i && eot_i |=> no_q == '0)
    else $error("offset not reset after end of text");

endmodule
`default_nettype wire

### design/sts_back.sv
// Back part: token queue that takes up to two words per cycle and hands out one.
`default_nettype none
module sts_back #(
  parameter int WordBits = 128
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_i,
  input  wire logic [1:0]          wr_cnt_i,
  input  wire logic [WordBits-1:0] wr0_i,
  input  wire logic [WordBits-1:0] wr1_i,
  output logic                     room_o,
  output logic                     empty_o,
  input  wire logic                pop_i,
  output logic [WordBits-1:0]      head_o,
  output logic                     head_last_o
);

  localparam int Depth = 4;
  logic [WordBits:0] mem_q [Depth];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q, cnt_d;
  logic do_pop;
  logic [1:0] wr_n;

  assign do_pop  = pop_i && !empty_o;
  assign wr_n    = wr_i ? wr_cnt_i : 2'd0;
  assign empty_o = cnt_q == 3'd0;
  // Two free entries needed for a worst-case character
  assign room_o  = cnt_q <= 3'(Depth - 2);
  assign cnt_d   = cnt_q + {1'b0, wr_n} - {2'b00, do_pop};
  assign head_o      = mem_q[rd_q][WordBits:1];
  assign head_last_o = mem_q[rd_q][0];

  // Storage
  always_ff @(posedge clk_i) begin
    if (wr_n != 2'd0) mem_q[wr_q] <= {wr0_i, wr_n == 2'd1};
    if (wr_n == 2'd2) mem_q[wr_q + 2'd1] <= {wr1_i, 1'b1};
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      rd_q  <= rd_q + {1'b0, do_pop};
      wr_q  <= wr_q + wr_n;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'(Depth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_n != 2'd0 |=> !empty_o)
    else $error("queue empty after write");
  assert property (@(posedge clk_i) disable iff (!rst_ni) empty_o |-> !do_pop)
    else $error("pop from empty queue");

endmodule
`default_nettype wire
